/* src/pqm_pkg.sv */
// pqm_pkg: shared constants, widths and request/response structs for the
// three-axis pid controller with x-frame motor mixer
// no dependencies; used by pqm_mul, pqm_div, pqm_mix and the top level
package pqm_pkg;

  // error and integral fixed-point formats
  localparam int ERR_FB    = 12;
  localparam int ERR_W     = 24;
  localparam int INT_FB    = 24;
  localparam int INT_UP_SH = INT_FB - ERR_FB;
  localparam int KI_RND    = 1 << (INT_UP_SH - 1);
  localparam int MIX_SH    = ERR_FB + 8;

  // limits and timing constants
  localparam int MIX_LIMIT = 250;
  localparam int MIX_W     = 9;
  localparam int MOTOR_MIN = 1000;
  localparam int MOTOR_MAX = 2000;
  localparam int MOTOR_W   = 11;
  localparam int THR_W     = 12;
  localparam int FIRST_DT  = 2;
  localparam int MIN_DT    = 1;
  localparam int MAX_DT    = 100;
  localparam int DT_W      = 7;
  localparam int MS_PER_S  = 1000;
  localparam int FILT_DIV  = 5;

  // gain register layout
  localparam int GAIN_W  = 16;
  localparam int GAINS_W = 3 * GAIN_W;

  // serial multiplier sizes
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = GAIN_W;
  localparam int PROD_W    = 64;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // serial divider sizes
  localparam int DIV_W     = 48;
  localparam int DEN_W     = 10;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic                       start;
    logic signed [MUL_A_W-1:0]  a;
    logic [MUL_B_W-1:0]         b;
  } mul_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [PROD_W-1:0]   prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                       start;
    logic [DIV_W-1:0]           num;
    logic [DEN_W-1:0]           den;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic [DIV_W-1:0]           q;
  } div_rsp_t;

endpackage

/* src/three_axis_pid_quad_mixer.sv */
// three_axis_pid_quad_mixer: roll/pitch/yaw pid with x-frame mixer
// an idle or repeated-timestamp request goes straight to the output step;
// when the pids run, each axis in turn does four serial multiplies and
// three serial divides; one request at a time, and the output step holds
// while an earlier result waits
// synchronous active-high reset clears all pid state, gains and time tracking
// depends on pqm_pkg, pqm_mul, pqm_div, pqm_mix
module three_axis_pid_quad_mixer (
  input  logic                             clk,
  input  logic                             rst,
  // apb configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [4:0]                       paddr,
  input  logic [63:0]                      pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready,
  // input requests
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             enable,
  input  logic [pqm_pkg::THR_W-1:0]        throttle,
  input  logic signed [pqm_pkg::ERR_W-1:0] roll_error,
  input  logic signed [pqm_pkg::ERR_W-1:0] pitch_error,
  input  logic signed [pqm_pkg::ERR_W-1:0] yaw_error,
  input  logic [31:0]                      sample_time,
  // output requests
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pqm_pkg::MOTOR_W-1:0]      motor_front_left,
  output logic [pqm_pkg::MOTOR_W-1:0]      motor_front_right,
  output logic [pqm_pkg::MOTOR_W-1:0]      motor_rear_right,
  output logic [pqm_pkg::MOTOR_W-1:0]      motor_rear_left
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_IMUL   = 4'd2;
  localparam logic [3:0] S_IDIV   = 4'd3;
  localparam logic [3:0] S_DDIV   = 4'd4;
  localparam logic [3:0] S_FDIV   = 4'd5;
  localparam logic [3:0] S_KP     = 4'd6;
  localparam logic [3:0] S_KI     = 4'd7;
  localparam logic [3:0] S_KD     = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam logic [1:0] REG_ROLL  = 2'd0;
  localparam logic [1:0] REG_PITCH = 2'd1;
  localparam logic [1:0] REG_YAW   = 2'd2;
  localparam logic [1:0] AX_LAST   = 2'd2;

  localparam int RI_W  = 45;
  localparam int RD_W  = 36;
  localparam int FX_W  = 38;
  localparam int ACC_W = 52;
  localparam int T3_W  = ACC_W + 2;

  localparam logic signed [31:0]   INT_LIM  = 32'sd1677721600;
  localparam logic signed [RI_W-1:0] INT_LIM_W = RI_W'(INT_LIM);
  localparam logic signed [FX_W-1:0] F_MAX  = 38'sd2147483647;
  localparam logic signed [FX_W-1:0] F_MIN  = -38'sd2147483648;
  localparam logic signed [pqm_pkg::MIX_W-1:0] MIX_POS = pqm_pkg::MIX_W'(pqm_pkg::MIX_LIMIT);

  // configuration and pid state
  logic [pqm_pkg::GAINS_W-1:0]       gains [3];
  logic signed [31:0]                integ [3];
  logic signed [pqm_pkg::ERR_W-1:0]  prev  [3];
  logic signed [31:0]                filt  [3];
  logic signed [pqm_pkg::MIX_W-1:0]  mixr  [3];
  logic [31:0]                       last_time;
  logic                              time_seen;

  // captured request
  logic                              c_enable;
  logic [pqm_pkg::THR_W-1:0]         c_thr;
  logic signed [pqm_pkg::ERR_W-1:0]  c_err [3];
  logic [31:0]                       c_time;

  // sequencer and datapath registers
  logic [3:0]                        state;
  logic [1:0]                        ax;
  logic                              launched;
  logic                              idle_out;
  logic [pqm_pkg::DT_W-1:0]          dt;
  logic [pqm_pkg::DIV_W-1:0]         int_num;
  logic                              int_neg;
  logic signed [RI_W-1:0]            raw_i;
  logic signed [RD_W-1:0]            raw_d;
  logic signed [31:0]                f_reg;
  logic signed [ACC_W-1:0]           acc;

  // shared units
  pqm_pkg::mul_req_t mul_req;
  pqm_pkg::mul_rsp_t mul_rsp;
  pqm_pkg::div_req_t div_req;
  pqm_pkg::div_rsp_t div_rsp;

  // combinational datapath
  logic signed [pqm_pkg::ERR_W-1:0]  e_cur, prev_cur;
  logic signed [31:0]                integ_cur, filt_cur;
  logic [pqm_pkg::GAIN_W-1:0]        kp, ki, kd;
  logic signed [pqm_pkg::ERR_W:0]    diff;
  logic signed [RD_W-1:0]            diff_k;
  logic [RD_W-1:0]                   d_mag;
  logic signed [FX_W-1:0]            x;
  logic [FX_W-1:0]                   x_mag;
  logic signed [pqm_pkg::DIV_W-1:0]  q_s;
  logic signed [pqm_pkg::DIV_W-1:0]  i_step;
  logic signed [RI_W-1:0]            raw_i_next;
  logic signed [RD_W-1:0]            raw_d_next;
  logic signed [FX_W-1:0]            f_full;
  logic signed [31:0]                f_sat;
  logic [pqm_pkg::PROD_W-1:0]        p_abs;
  logic [pqm_pkg::PROD_W-1:0]        ki_mag;
  logic signed [ACC_W-1:0]           ki_term;
  logic [ACC_W-1:0]                  ap;
  logic [T3_W-1:0]                   t3;
  logic                              sat;
  logic [pqm_pkg::MIX_W-1:0]         mix_mag;
  logic signed [pqm_pkg::MIX_W-1:0]  mix_v;
  logic signed [31:0]                ri_c;
  logic [31:0]                       d32;
  logic [pqm_pkg::DT_W-1:0]          dt_v;
  logic [pqm_pkg::MOTOR_W-1:0]       thr_c;
  logic [pqm_pkg::MOTOR_W-1:0]       m_fl, m_fr, m_rr, m_rl;
  logic                              cfg_wr;

  always_comb begin
    e_cur     = c_err[ax];
    prev_cur  = prev[ax];
    integ_cur = integ[ax];
    filt_cur  = filt[ax];
    kp        = gains[ax][pqm_pkg::GAIN_W-1:0];
    ki        = gains[ax][2*pqm_pkg::GAIN_W-1:pqm_pkg::GAIN_W];
    kd        = gains[ax][3*pqm_pkg::GAIN_W-1:2*pqm_pkg::GAIN_W];

    // derivative numerator: error change times 1000
    diff   = (pqm_pkg::ERR_W+1)'(e_cur) - (pqm_pkg::ERR_W+1)'(prev_cur);
    diff_k = (RD_W'(diff) <<< 10) - (RD_W'(diff) <<< 4) - (RD_W'(diff) <<< 3);
    d_mag  = diff_k[RD_W-1] ? RD_W'(-diff_k) : RD_W'(diff_k);

    // filter step numerator
    x     = FX_W'(raw_d) - FX_W'(filt_cur);
    x_mag = x[FX_W-1] ? FX_W'(-x) : FX_W'(x);

    // signed results of the divider
    q_s        = $signed(div_rsp.q);
    i_step     = int_neg ? -q_s : q_s;
    raw_i_next = RI_W'(pqm_pkg::DIV_W'(integ_cur) + i_step);
    raw_d_next = RD_W'(diff_k[RD_W-1] ? -q_s : q_s);
    f_full     = FX_W'(filt_cur) + FX_W'(x[FX_W-1] ? -q_s : q_s);
    if (f_full > F_MAX) begin
      f_sat = 32'sh7FFFFFFF;
    end else if (f_full < F_MIN) begin
      f_sat = 32'sh80000000;
    end else begin
      f_sat = 32'(f_full);
    end

    // product magnitude and rounded integral term
    p_abs   = mul_rsp.prod[pqm_pkg::PROD_W-1] ? pqm_pkg::PROD_W'(-mul_rsp.prod)
                                              : pqm_pkg::PROD_W'(mul_rsp.prod);
    ki_mag  = (p_abs + pqm_pkg::PROD_W'(pqm_pkg::KI_RND)) >> pqm_pkg::INT_UP_SH;
    ki_term = mul_rsp.prod[pqm_pkg::PROD_W-1] ? -$signed(ACC_W'(ki_mag))
                                              : $signed(ACC_W'(ki_mag));

    // saturation and mix term
    ap      = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    t3      = T3_W'(ap) + (T3_W'(ap) << 1);
    sat     = t3 > (T3_W'(pqm_pkg::MIX_LIMIT) << pqm_pkg::MIX_SH);
    mix_mag = pqm_pkg::MIX_W'(t3 >> pqm_pkg::MIX_SH);
    if (sat) begin
      mix_v = acc[ACC_W-1] ? -MIX_POS : MIX_POS;
    end else begin
      mix_v = acc[ACC_W-1] ? -$signed(mix_mag) : $signed(mix_mag);
    end

    // integral clamp
    if (raw_i > INT_LIM_W) begin
      ri_c = INT_LIM;
    end else if (raw_i < -INT_LIM_W) begin
      ri_c = -INT_LIM;
    end else begin
      ri_c = 32'(raw_i);
    end

    // sample interval
    d32 = c_time - last_time;
    if (!time_seen) begin
      dt_v = pqm_pkg::DT_W'(pqm_pkg::FIRST_DT);
    end else if (d32 < 32'(pqm_pkg::MIN_DT)) begin
      dt_v = pqm_pkg::DT_W'(pqm_pkg::MIN_DT);
    end else if (d32 > 32'(pqm_pkg::MAX_DT)) begin
      dt_v = pqm_pkg::DT_W'(pqm_pkg::MAX_DT);
    end else begin
      dt_v = d32[pqm_pkg::DT_W-1:0];
    end

    thr_c = (c_thr > pqm_pkg::THR_W'(pqm_pkg::MOTOR_MAX)) ?
            pqm_pkg::MOTOR_W'(pqm_pkg::MOTOR_MAX) : c_thr[pqm_pkg::MOTOR_W-1:0];
  end

  // multiplier operand select
  always_comb begin
    mul_req.start = !launched &&
                    (state == S_IMUL || state == S_KP || state == S_KI || state == S_KD);
    case (state)
      S_IMUL: begin
        mul_req.a = pqm_pkg::MUL_A_W'(e_cur);
        mul_req.b = pqm_pkg::MUL_B_W'(dt);
      end
      S_KP: begin
        mul_req.a = pqm_pkg::MUL_A_W'(e_cur);
        mul_req.b = kp;
      end
      S_KI: begin
        mul_req.a = pqm_pkg::MUL_A_W'(raw_i);
        mul_req.b = ki;
      end
      S_KD: begin
        mul_req.a = pqm_pkg::MUL_A_W'(f_reg);
        mul_req.b = kd;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // divider operand select, rounding offset added ahead of the divide
  always_comb begin
    div_req.start = !launched &&
                    (state == S_IDIV || state == S_DDIV || state == S_FDIV);
    case (state)
      S_IDIV: begin
        div_req.num = int_num;
        div_req.den = pqm_pkg::DEN_W'(pqm_pkg::MS_PER_S);
      end
      S_DDIV: begin
        div_req.num = pqm_pkg::DIV_W'(d_mag) + pqm_pkg::DIV_W'(dt >> 1);
        div_req.den = pqm_pkg::DEN_W'(dt);
      end
      S_FDIV: begin
        div_req.num = pqm_pkg::DIV_W'(x_mag) + pqm_pkg::DIV_W'(pqm_pkg::FILT_DIV / 2);
        div_req.den = pqm_pkg::DEN_W'(pqm_pkg::FILT_DIV);
      end
      default: begin
        div_req.num = '0;
        div_req.den = '0;
      end
    endcase
  end

  pqm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  pqm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pqm_mix u_mix (
    .thr         (thr_c),
    .roll        (mixr[0]),
    .pitch       (mixr[1]),
    .yaw         (mixr[2]),
    .front_left  (m_fl),
    .front_right (m_fr),
    .rear_right  (m_rr),
    .rear_left   (m_rl)
  );

  // apb access
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (paddr[4:3])
      REG_ROLL:  prdata = 64'(gains[0]);
      REG_PITCH: prdata = 64'(gains[1]);
      REG_YAW:   prdata = 64'(gains[2]);
      default:   prdata = '0;
    endcase
  end

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      time_seen <= 1'b0;
      last_time <= '0;
      ax        <= '0;
      for (int i = 0; i < 3; i++) begin
        gains[i] <= '0;
        integ[i] <= '0;
        prev[i]  <= '0;
        filt[i]  <= '0;
        mixr[i]  <= '0;
      end
    end else begin
      // register writes
      if (cfg_wr) begin
        case (paddr[4:3])
          REG_ROLL:  gains[0] <= pwdata[pqm_pkg::GAINS_W-1:0];
          REG_PITCH: gains[1] <= pwdata[pqm_pkg::GAINS_W-1:0];
          REG_YAW:   gains[2] <= pwdata[pqm_pkg::GAINS_W-1:0];
          default:   ;
        endcase
      end

      // result taken while no new one is being loaded
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_enable <= enable;
            c_thr    <= throttle;
            c_err[0] <= roll_error;
            c_err[1] <= pitch_error;
            c_err[2] <= yaw_error;
            c_time   <= sample_time;
            state    <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!c_enable || c_thr <= pqm_pkg::THR_W'(pqm_pkg::MOTOR_MIN)) begin
            idle_out <= 1'b1;
            state    <= S_OUT;
          end else begin
            idle_out <= 1'b0;
            if (!time_seen || c_time != last_time) begin
              dt        <= dt_v;
              last_time <= c_time;
              time_seen <= 1'b1;
              ax        <= '0;
              state     <= S_IMUL;
            end else begin
              state <= S_OUT;
            end
          end
        end
        // error times dt, scaled to integral format
        S_IMUL: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_rsp.done) begin
            launched <= 1'b0;
            int_num  <= (pqm_pkg::DIV_W'(p_abs) << pqm_pkg::INT_UP_SH) +
                        pqm_pkg::DIV_W'(pqm_pkg::MS_PER_S / 2);
            int_neg  <= mul_rsp.prod[pqm_pkg::PROD_W-1];
            state    <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_rsp.done) begin
            launched <= 1'b0;
            raw_i    <= raw_i_next;
            state    <= S_DDIV;
          end
        end
        S_DDIV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_rsp.done) begin
            launched <= 1'b0;
            raw_d    <= raw_d_next;
            state    <= S_FDIV;
          end
        end
        // derivative low-pass
        S_FDIV: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (div_rsp.done) begin
            launched  <= 1'b0;
            f_reg     <= f_sat;
            filt[ax]  <= f_sat;
            state     <= S_KP;
          end
        end
        S_KP: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_rsp.done) begin
            launched <= 1'b0;
            acc      <= ACC_W'(mul_rsp.prod);
            state    <= S_KI;
          end
        end
        S_KI: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_rsp.done) begin
            launched <= 1'b0;
            acc      <= acc + ki_term;
            state    <= S_KD;
          end
        end
        S_KD: begin
          if (!launched) begin
            launched <= 1'b1;
          end else if (mul_rsp.done) begin
            launched <= 1'b0;
            acc      <= acc + ACC_W'(mul_rsp.prod);
            state    <= S_FIN;
          end
        end
        // saturation check, integral freeze, next axis
        S_FIN: begin
          if (!sat) begin
            integ[ax] <= ri_c;
          end
          prev[ax] <= e_cur;
          mixr[ax] <= mix_v;
          if (ax == AX_LAST) begin
            state <= S_OUT;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_IMUL;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            if (idle_out) begin
              motor_front_left  <= pqm_pkg::MOTOR_W'(pqm_pkg::MOTOR_MIN);
              motor_front_right <= pqm_pkg::MOTOR_W'(pqm_pkg::MOTOR_MIN);
              motor_rear_right  <= pqm_pkg::MOTOR_W'(pqm_pkg::MOTOR_MIN);
              motor_rear_left   <= pqm_pkg::MOTOR_W'(pqm_pkg::MOTOR_MIN);
            end else begin
              motor_front_left  <= m_fl;
              motor_front_right <= m_fr;
              motor_rear_right  <= m_rr;
              motor_rear_left   <= m_rl;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // integrators stay inside the clamp
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (integ[0] <= INT_LIM) && (integ[0] >= -INT_LIM) &&
    (integ[1] <= INT_LIM) && (integ[1] >= -INT_LIM) &&
    (integ[2] <= INT_LIM) && (integ[2] >= -INT_LIM))
    else $error("integral outside clamp");

  // held mix terms stay within the axis limit
  a_mix_range: assert property (@(posedge clk) disable iff (rst)
    (mixr[0] <= MIX_POS) && (mixr[0] >= -MIX_POS) &&
    (mixr[1] <= MIX_POS) && (mixr[1] >= -MIX_POS) &&
    (mixr[2] <= MIX_POS) && (mixr[2] >= -MIX_POS))
    else $error("mix term outside limit");

  // a new result only comes from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output step");

  // an accepted request always goes to the decision step
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECIDE))
    else $error("accepted request not decoded");

endmodule

/* src/pqm_mul.sv */
// pqm_mul: shift-and-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier; depends on pqm_pkg
module pqm_mul (
  input  logic               clk,
  input  logic               rst,
  input  pqm_pkg::mul_req_t  req,
  output pqm_pkg::mul_rsp_t  rsp
);

  logic signed [pqm_pkg::PROD_W-1:0]  mcand;
  logic [pqm_pkg::MUL_B_W-1:0]        mplier;
  logic signed [pqm_pkg::PROD_W-1:0]  prod;
  logic [pqm_pkg::MUL_CNT_W-1:0]      cnt;
  logic                               done;

  // bit counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == pqm_pkg::MUL_CNT_W'(1));
      if (req.start) begin
        cnt <= pqm_pkg::MUL_CNT_W'(pqm_pkg::MUL_B_W);
      end else if (cnt != '0) begin
        cnt <= cnt - pqm_pkg::MUL_CNT_W'(1);
      end
    end
  end

  // shift registers and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= pqm_pkg::PROD_W'(req.a);
      mplier <= req.b;
      prod   <= '0;
    end else if (cnt != '0) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = prod;

endmodule

/* src/pqm_div.sv */
// pqm_div: restoring divider, one quotient bit per cycle
// unsigned numerator over a narrow unsigned divisor; depends on pqm_pkg
module pqm_div (
  input  logic               clk,
  input  logic               rst,
  input  pqm_pkg::div_req_t  req,
  output pqm_pkg::div_rsp_t  rsp
);

  logic [pqm_pkg::DIV_W-1:0]      quo;
  logic [pqm_pkg::DEN_W-1:0]      rem;
  logic [pqm_pkg::DEN_W-1:0]      den;
  logic [pqm_pkg::DIV_CNT_W-1:0]  cnt;
  logic                           done;
  logic [pqm_pkg::DEN_W:0]        rem_sh;
  logic                           ge;

  // trial subtract of the next numerator bit
  always_comb begin
    rem_sh = {rem, quo[pqm_pkg::DIV_W-1]};
    ge     = (rem_sh >= {1'b0, den});
  end

  // bit counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == pqm_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        cnt <= pqm_pkg::DIV_CNT_W'(pqm_pkg::DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - pqm_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (cnt != '0) begin
      rem <= ge ? pqm_pkg::DEN_W'(rem_sh - {1'b0, den}) : pqm_pkg::DEN_W'(rem_sh);
      quo <= {quo[pqm_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.q    = quo;

endmodule

/* src/pqm_mix.sv */
// pqm_mix: x-frame mixer from throttle and three axis terms to four pulses
// each pulse clamped to the motor range; depends on pqm_pkg
module pqm_mix (
  input  logic [pqm_pkg::MOTOR_W-1:0]       thr,
  input  logic signed [pqm_pkg::MIX_W-1:0]  roll,
  input  logic signed [pqm_pkg::MIX_W-1:0]  pitch,
  input  logic signed [pqm_pkg::MIX_W-1:0]  yaw,
  output logic [pqm_pkg::MOTOR_W-1:0]       front_left,
  output logic [pqm_pkg::MOTOR_W-1:0]       front_right,
  output logic [pqm_pkg::MOTOR_W-1:0]       rear_right,
  output logic [pqm_pkg::MOTOR_W-1:0]       rear_left
);

  localparam int SUM_W = pqm_pkg::MOTOR_W + 2;

  logic signed [SUM_W-1:0] base, r, p, y;
  logic signed [SUM_W-1:0] s_fl, s_fr, s_rr, s_rl;

  function automatic logic [pqm_pkg::MOTOR_W-1:0] clamp_motor(
    input logic signed [SUM_W-1:0] v
  );
    logic [pqm_pkg::MOTOR_W-1:0] res;
    if (v < SUM_W'(pqm_pkg::MOTOR_MIN)) begin
      res = pqm_pkg::MOTOR_W'(pqm_pkg::MOTOR_MIN);
    end else if (v > SUM_W'(pqm_pkg::MOTOR_MAX)) begin
      res = pqm_pkg::MOTOR_W'(pqm_pkg::MOTOR_MAX);
    end else begin
      res = v[pqm_pkg::MOTOR_W-1:0];
    end
    return res;
  endfunction

  // motor sums
  always_comb begin
    base = $signed({2'b00, thr});
    r    = SUM_W'(roll);
    p    = SUM_W'(pitch);
    y    = SUM_W'(yaw);
    s_fl = base + p + r - y;
    s_fr = base + p - r + y;
    s_rr = base - p - r - y;
    s_rl = base - p + r + y;
  end

  assign front_left  = clamp_motor(s_fl);
  assign front_right = clamp_motor(s_fr);
  assign rear_right  = clamp_motor(s_rr);
  assign rear_left   = clamp_motor(s_rl);

endmodule
